FILE: hw/rtl/ptrs_pkg.sv
// ----------------------------------------------------------------------------
// ptrs_pkg: shared types and helpers for the pixel tint / rotate / swap core
// Register indexes, the configuration struct and the blend/clamp functions.
// ----------------------------------------------------------------------------
package ptrs_pkg;

    localparam int PIX_W   = 16;
    localparam int CH_W    = 8;
    localparam int WGT_W   = 7;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 8;

    typedef enum logic [CFG_A_W-1:0] {
        REG_RED_OFFSET   = 3'd0,
        REG_GREEN_OFFSET = 3'd1,
        REG_BLUE_OFFSET  = 3'd2,
        REG_ROTATION     = 3'd3,
        REG_SWAP         = 3'd4,
        REG_PIXEL_FORMAT = 3'd5
    } reg_index_t;

    localparam logic [CH_W-1:0] NEUTRAL = 8'd128;

    // Decoded settings, consumed by the pipeline
    typedef struct packed {
        logic [CH_W-1:0]  off_r;
        logic [CH_W-1:0]  off_g;
        logic [CH_W-1:0]  off_b;
        logic [WGT_W-1:0] rot_w;
        logic             rot_dn;   // rotation register below 128
        logic [WGT_W-1:0] swap_w;
        logic             fmt565;
        logic             bypass;   // all amount registers neutral
    } cfg_t;

    // |reg - 128|, capped at 127
    function automatic logic [WGT_W-1:0] weight_of(input logic [CH_W-1:0] v);
        logic [CH_W-1:0] d;
        d = v[7] ? (v - NEUTRAL) : (NEUTRAL - v);
        return d[7] ? 7'd127 : d[WGT_W-1:0];
    endfunction

    // channel + offset - 128, clamped to 0..255
    function automatic logic [CH_W-1:0] add_clamp(input logic [CH_W-1:0] ch,
                                                  input logic [CH_W-1:0] off);
        logic signed [9:0] s;
        s = $signed({2'b00, ch}) + $signed({2'b00, off}) - 10'sd128;
        if (s < 10'sd0)
            return 8'd0;
        else if (s > 10'sd255)
            return 8'd255;
        else
            return s[CH_W-1:0];
    endfunction

    // (w*a + (127-w)*b) >> 7; never exceeds 253
    function automatic logic [CH_W-1:0] blend(input logic [WGT_W-1:0] w,
                                              input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
        logic [WGT_W-1:0] wi;
        logic [14:0]      acc;
        wi  = ~w;   // 127 - w at 7 bits
        acc = 15'(w) * 15'(a) + 15'(wi) * 15'(b);
        return acc[14:7];
    endfunction

endpackage

FILE: hw/rtl/ptrs_cfg.sv
// ----------------------------------------------------------------------------
// ptrs_cfg: configuration register file
// Holds the six settings and decodes weights, direction and bypass.
// ----------------------------------------------------------------------------
module ptrs_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [ptrs_pkg::CFG_A_W-1:0] cfg_index,
    input  logic [ptrs_pkg::CFG_D_W-1:0] cfg_data,
    output ptrs_pkg::cfg_t               cfg
);
    import ptrs_pkg::*;

    logic [CH_W-1:0] red_reg, green_reg, blue_reg, rot_reg, swap_reg;
    logic            fmt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg   <= NEUTRAL;
            green_reg <= NEUTRAL;
            blue_reg  <= NEUTRAL;
            rot_reg   <= NEUTRAL;
            swap_reg  <= NEUTRAL;
            fmt_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RED_OFFSET:   red_reg   <= cfg_data;
                REG_GREEN_OFFSET: green_reg <= cfg_data;
                REG_BLUE_OFFSET:  blue_reg  <= cfg_data;
                REG_ROTATION:     rot_reg   <= cfg_data;
                REG_SWAP:         swap_reg  <= cfg_data;
                REG_PIXEL_FORMAT: fmt_reg   <= cfg_data[0];
                default: ;        // unmapped index: ignored
            endcase
        end
    end

    always_comb begin
        cfg.off_r  = red_reg;
        cfg.off_g  = green_reg;
        cfg.off_b  = blue_reg;
        cfg.rot_w  = weight_of(rot_reg);
        cfg.rot_dn = ~rot_reg[7];
        cfg.swap_w = weight_of(swap_reg);
        cfg.fmt565 = fmt_reg;
        cfg.bypass = (red_reg == NEUTRAL) && (green_reg == NEUTRAL) &&
                     (blue_reg == NEUTRAL) && (rot_reg == NEUTRAL) &&
                     (swap_reg == NEUTRAL);
    end

endmodule

FILE: hw/rtl/pixel_tint_rotate_swap_core.sv
// ----------------------------------------------------------------------------
// pixel_tint_rotate_swap_core: pixel tint, channel rotate and red/blue swap
// Three-stage stream pipeline on packed RGB565 / RGB555 pixels.
// ----------------------------------------------------------------------------
// Pipeline: 3 register stages (stage 1, stage 2 and the output register);
//   m_tdata is driven straight from the output register.
// Throughput: one pixel per clock; the three stage registers each advance
//   whenever the stage ahead is empty or moving, so only m_tready stalls it.
// Reset (aresetn low, synchronous): all stage valids clear, settings return
//   to neutral (offsets/amounts 128, RGB565), i.e. a pure pass-through.
// ----------------------------------------------------------------------------
module pixel_tint_rotate_swap_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] pixel_in
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [15:0] pixel_out
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic [ptrs_pkg::CFG_A_W-1:0] cfg_index,
    input  logic [ptrs_pkg::CFG_D_W-1:0] cfg_data
);
    import ptrs_pkg::*;

    cfg_t cfg;

    ptrs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage handshake: a stage loads when it is empty or its holder moves on
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // ---------------- Stage 1: unpack, offset, clamp ----------------
    logic [CH_W-1:0] r_next, g_next, b_next;
    logic            zero_next;
    logic [CH_W-1:0] r1_reg, g1_reg, b1_reg;
    logic [15:0]     pix1_reg;
    logic            zero1_reg;

    always_comb begin
        logic [CH_W-1:0] ur, ug, ub;
        if (cfg.fmt565) begin
            ur = {s_tdata[15:11], 3'b000};
            ug = {s_tdata[10:5], 2'b00};
        end else begin
            ur = {s_tdata[14:10], 3'b000};
            ug = {s_tdata[9:5], 3'b000};
        end
        ub        = {s_tdata[4:0], 3'b000};
        r_next    = add_clamp(ur, cfg.off_r);
        g_next    = add_clamp(ug, cfg.off_g);
        b_next    = add_clamp(ub, cfg.off_b);
        // in 555 bit 15 is not part of the colour code
        zero_next = (s_tdata[14:0] == 15'd0) && (!cfg.fmt565 || !s_tdata[15]);
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            r1_reg    <= r_next;
            g1_reg    <= g_next;
            b1_reg    <= b_next;
            pix1_reg  <= s_tdata;
            zero1_reg <= zero_next;
        end
    end

    // ---------------- Stage 2: channel rotation blend ----------------
    logic [CH_W-1:0] rr2_reg, rg2_reg, rb2_reg;
    logic [15:0]     pix2_reg;
    logic            zero2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            if (cfg.rot_dn) begin   // r<-b, g<-r, b<-g
                rr2_reg <= blend(cfg.rot_w, b1_reg, r1_reg);
                rg2_reg <= blend(cfg.rot_w, r1_reg, g1_reg);
                rb2_reg <= blend(cfg.rot_w, g1_reg, b1_reg);
            end else begin          // r<-g, g<-b, b<-r
                rr2_reg <= blend(cfg.rot_w, g1_reg, r1_reg);
                rg2_reg <= blend(cfg.rot_w, b1_reg, g1_reg);
                rb2_reg <= blend(cfg.rot_w, r1_reg, b1_reg);
            end
            pix2_reg  <= pix1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // ---------------- Stage 3: swap blend, repack, output register ----------
    // Blends stay within 0..253, so no final clamp is needed.
    logic [15:0] out_next;
    logic [15:0] out_reg;
    logic        zero3_reg;
    logic        byp3_reg;
    logic        fmt3_reg;

    always_comb begin
        logic [CH_W-1:0] sr, sb;
        logic [15:0]     packed_px;
        sr = blend(cfg.swap_w, rb2_reg, rr2_reg);
        sb = blend(cfg.swap_w, rr2_reg, rb2_reg);
        if (cfg.fmt565)
            packed_px = {sr[7:3], rg2_reg[7:2], sb[7:3]};
        else
            packed_px = {1'b0, sr[7:3], rg2_reg[7:3], sb[7:3]};
        // a nonzero code never packs to zero
        if (packed_px == 16'd0)
            packed_px = 16'd1;
        if (zero2_reg)
            packed_px = 16'd0;
        if (!cfg.fmt565)
            packed_px[15] = pix2_reg[15];
        out_next = cfg.bypass ? pix2_reg : packed_px;
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            out_reg   <= out_next;
            zero3_reg <= zero2_reg;
            byp3_reg  <= cfg.bypass;
            fmt3_reg  <= cfg.fmt565;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = out_reg;

    // ---------------- Assertions ----------------
    // Only output backpressure can stall the request side
    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("request side stalled without output backpressure");

    // A zero colour code leaves the core as zero (outside bypass)
    a_zero_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && zero3_reg && !byp3_reg) |-> (m_tdata[14:0] == 15'd0))
        else $error("zero pixel not preserved");

    // A tinted nonzero code never packs to zero (565 code is all 16 bits)
    a_nonzero_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !zero3_reg && !byp3_reg) |->
            (fmt3_reg ? (m_tdata != 16'd0) : (m_tdata[14:0] != 15'd0)))
        else $error("nonzero pixel packed to zero");

    // Pipeline is empty in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!v1_reg && !v2_reg && !m_tvalid))
        else $error("pipeline valid after reset");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for pixel_tint_rotate_swap_core
// Streams packed RGB565 / RGB555 pixels through the core under a series of
// register settings. A scoreboard computes each tinted pixel from its own copy
// of the settings and checks results in order. Both stream sides idle at
// random, with some phases running flat out.
// ----------------------------------------------------------------------------
module tb;
    import ptrs_pkg::*;

    // Indexes past the last register; writes there must change nothing
    localparam logic [CFG_A_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int MAX_GAP        = 18;
    localparam int DRAIN_CYCLES   = 8;     // idle margin with the core empty
    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
    localparam int NUM_PHASES     = 14;
    localparam int PHASE_ITEMS    = 75;
    localparam int NUM_FIXED      = 6;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the settings and predicts each tinted pixel
    // ------------------------------------------------------------------------
    class tint_scoreboard;
        typedef struct {
            logic [15:0] src;
            logic [15:0] tinted;
        } tint_entry_t;

        logic [7:0]  red_off, green_off, blue_off, rot_amt, swap_amt;
        bit          fmt565;
        tint_entry_t expected_pixels[$];
        int unsigned mismatches;
        int unsigned strays;
        int unsigned checked;

        function new();
            red_off   = NEUTRAL;
            green_off = NEUTRAL;
            blue_off  = NEUTRAL;
            rot_amt   = NEUTRAL;
            swap_amt  = NEUTRAL;
            fmt565    = 1'b1;
            mismatches = 0;
            strays     = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] data);
            case (idx)
                REG_RED_OFFSET:   red_off   = data;
                REG_GREEN_OFFSET: green_off = data;
                REG_BLUE_OFFSET:  blue_off  = data;
                REG_ROTATION:     rot_amt   = data;
                REG_SWAP:         swap_amt  = data;
                REG_PIXEL_FORMAT: fmt565    = data[0];
                default: ;
            endcase
        endfunction

        function int clamp_ch(int v);
            if (v < 0) return 0;
            if (v > 255) return 255;
            return v;
        endfunction

        // distance from neutral, capped at 127
        function int blend_weight(logic [7:0] v);
            int d;
            d = (v >= NEUTRAL) ? int'(v) - 128 : 128 - int'(v);
            return (d > 127) ? 127 : d;
        endfunction

        function logic [15:0] tinted_code(logic [15:0] code, bit is565);
            int r, g, b, wr, ws, rr, rg, rb, sr, sbl;
            logic [15:0] px;
            if (code == 16'h0000) return 16'h0000;
            if (is565) begin
                r = int'(code[15:11]) * 8;
                g = int'(code[10:5]) * 4;
                b = int'(code[4:0]) * 8;
            end else begin
                r = int'(code[14:10]) * 8;
                g = int'(code[9:5]) * 8;
                b = int'(code[4:0]) * 8;
            end
            r = clamp_ch(r + int'(red_off) - 128);
            g = clamp_ch(g + int'(green_off) - 128);
            b = clamp_ch(b + int'(blue_off) - 128);
            wr = blend_weight(rot_amt);
            ws = blend_weight(swap_amt);
            if (rot_amt < NEUTRAL) begin
                rr = (wr * b + (127 - wr) * r) >> 7;
                rg = (wr * r + (127 - wr) * g) >> 7;
                rb = (wr * g + (127 - wr) * b) >> 7;
            end else begin
                rr = (wr * g + (127 - wr) * r) >> 7;
                rg = (wr * b + (127 - wr) * g) >> 7;
                rb = (wr * r + (127 - wr) * b) >> 7;
            end
            sr  = clamp_ch((ws * rb + (127 - ws) * rr) >> 7);
            sbl = clamp_ch((ws * rr + (127 - ws) * rb) >> 7);
            rg  = clamp_ch(rg);
            if (is565)
                px = 16'(((sr >> 3) << 11) | ((rg >> 2) << 5) | (sbl >> 3));
            else
                px = 16'(((sr >> 3) << 10) | ((rg >> 3) << 5) | (sbl >> 3));
            return (px == 16'h0000) ? 16'h0001 : px;
        endfunction

        function logic [15:0] tinted_pixel(logic [15:0] p);
            if (red_off == NEUTRAL && green_off == NEUTRAL && blue_off == NEUTRAL &&
                rot_amt == NEUTRAL && swap_amt == NEUTRAL)
                return p;
            if (fmt565)
                return tinted_code(p, 1'b1);
            return {p[15], 15'h0} | tinted_code({1'b0, p[14:0]}, 1'b0);
        endfunction

        function void note_request(logic [15:0] p);
            tint_entry_t e;
            e.src    = p;
            e.tinted = tinted_pixel(p);
            expected_pixels.push_back(e);
        endfunction

        function void check_result(logic [15:0] got);
            tint_entry_t e;
            if (expected_pixels.size() == 0) begin
                strays++;
                $display("ERROR: result %h arrived with nothing outstanding", got);
                return;
            end
            e = expected_pixels.pop_front();
            checked++;
            if (got !== e.tinted) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: pixel_in %h: pixel_out exp %h got %h",
                             e.src, e.tinted, got);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = 16'h0000;   // [15:0] pixel_in
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;                // [15:0] pixel_out
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0]   cfg_index = REG_RED_OFFSET;
    logic [CFG_D_W-1:0]   cfg_data  = NEUTRAL;

    tint_scoreboard sb;

    // idle control, changed per phase
    bit          src_no_gap  = 1'b0;
    bit          sink_no_gap = 1'b0;
    bit          reset_done  = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned sent        = 0;
    int unsigned phases_run  = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pixel_tint_rotate_swap_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Monitors: values read at the edge are the pre-edge ones
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog: any request, result or register write counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("pixel_tint_rotate_swap_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random backpressure, drawn per result
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        wait (reset_done);
        forever begin
            gap = sink_no_gap ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_pixel(input logic [15:0] px);
        int gap;
        gap = src_no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // Stop the request stream and wait until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes all six registers plus the spare indexes, back to back.
    // Upper data bits of the format register are junk on purpose.
    task automatic apply_settings(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input logic [7:0] rot,
                                  input logic [7:0] swp, input bit fmt);
        logic [CFG_A_W-1:0] idx [8];
        logic [CFG_D_W-1:0] val [8];
        idx = '{REG_RED_OFFSET, REG_GREEN_OFFSET, REG_BLUE_OFFSET, REG_ROTATION,
                REG_SWAP, REG_PIXEL_FORMAT, REG_SPARE_LO, REG_SPARE_HI};
        val = '{r, g, b, rot, swp, {7'($urandom), fmt}, 8'($urandom), 8'($urandom)};
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_wr_en <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        phases_run++;
    endtask

    // Register value biased toward the edges and the neutral point
    function automatic logic [7:0] pick_amount();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return NEUTRAL;
            3: return NEUTRAL - 8'd1;
            4: return NEUTRAL + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 19))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h8000 | 16'($urandom_range(1, 7));
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] corner_pixels [12];
        logic [7:0]  fixed_set [NUM_FIXED][5];
        bit          fixed_fmt [NUM_FIXED];
        int          fails;

        sb = new();
        // black, white, bit 15 alone, all code bits, lsb, each channel full, two alternating patterns
        corner_pixels = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hF800,
                          16'h07E0, 16'h001F, 16'h7C00, 16'h03E0, 16'h5555, 16'hAAAA};
        // offsets r/g/b, rotation, swap
        fixed_set = '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
                      '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
                      '{NEUTRAL, NEUTRAL, NEUTRAL, NEUTRAL, NEUTRAL},
                      '{NEUTRAL, NEUTRAL, NEUTRAL, 8'd0,   8'd255},
                      '{8'd255, 8'd0,   NEUTRAL, 8'd255, 8'd0},
                      '{NEUTRAL, NEUTRAL, NEUTRAL, 8'd127, 8'd129}};
        fixed_fmt = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        reset_done = 1'b1;

        // Directed: corner pixels in the reset state (pass-through) ...
        foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
        drain();
        // ... and with every amount at zero in RGB555: full negative tint,
        // weights capped at 127, tinted codes collapsing to black become 1
        apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
        drain();

        // Random phases: fixed settings (extremes and neutral) first, then random settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < NUM_FIXED)
                apply_settings(fixed_set[ph][0], fixed_set[ph][1], fixed_set[ph][2],
                               fixed_set[ph][3], fixed_set[ph][4], fixed_fmt[ph]);
            else
                apply_settings(pick_amount(), pick_amount(), pick_amount(),
                               pick_amount(), pick_amount(), 1'($urandom));
            // some phases run one or both sides without gaps
            src_no_gap  = ($urandom_range(0, 2) == 0);
            sink_no_gap = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) send_pixel(pick_pixel());
            drain();
        end

        if (sb.pending() != 0)
            $display("ERROR: %0d expected pixels never arrived", sb.pending());
        fails = sb.mismatches + sb.strays + sb.pending();
        $display("Summary: %0d pixels sent, %0d results checked, %0d register settings",
                 sent, sb.checked, phases_run + 1);
        $display("Summary: %0d mismatches, %0d results without a request",
                 sb.mismatches, sb.strays);
        if (fails == 0)
            $display("pixel_tint_rotate_swap_core: match");
        else
            $display("pixel_tint_rotate_swap_core: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ptrs_pkg.sv
hw/rtl/ptrs_cfg.sv
hw/rtl/pixel_tint_rotate_swap_core.sv
tb/tb.sv
